// ===== hw/rtl/eld_pkg.sv =====
// Package: shared constants and command types for the elevator LOOK dispatcher.
package eld_pkg;

  localparam int FLOOR_COUNT = 16;
  localparam int FLOOR_W     = $clog2(FLOOR_COUNT + 1);
  localparam int IDX_W       = $clog2(FLOOR_COUNT);
  localparam int FIELD_W     = 5;

  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_ARRIVE  = 2'd1;
  localparam logic [1:0] MODE_UPDATE  = 2'd2;
  localparam logic [1:0] MODE_CLOSED  = 2'd3;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_CAR     = 2'd1;
  localparam logic [1:0] KIND_HALL_UP = 2'd2;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [1:0] MOTOR_STOP = 2'd0;

  typedef struct packed {
    logic latch;
    logic commit;
    logic load_out;
  } eld_cmd_t;

endpackage

// ===== hw/rtl/elevator_look_dispatcher.sv =====
// Top level: elevator car dispatcher with LOOK-style target selection.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid, in_stall | mode, floor, request_kind, door_open
//   out     | out_valid,out_stall| forward_request, motor_valid, motor_cmd,
//           |                    | open_door, hall_clear, hall_clear_up,
//           |                    | car_floor, target_valid, target_floor
//
// An item is handled in steps: first the request bitmap is searched and car
// state updated, then the registered read of the request-kind store completes the result.
// A new item is taken only when idle or when the last one is loaded into the result registers.
// Reset (rst, synchronous) empties the request bitmap and parks the car at floor 1, idle.
// A result held under out_stall blocks only its successor's final stage.
module elevator_look_dispatcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic [eld_pkg::FIELD_W-1:0] floor,
  input  logic [1:0]                  request_kind,
  input  logic                        door_open,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        forward_request,
  output logic                        motor_valid,
  output logic [1:0]                  motor_cmd,
  output logic                        open_door,
  output logic                        hall_clear,
  output logic                        hall_clear_up,
  output logic [eld_pkg::FIELD_W-1:0] car_floor,
  output logic                        target_valid,
  output logic [eld_pkg::FIELD_W-1:0] target_floor
);
  import eld_pkg::*;

  eld_cmd_t cmd;

  eld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  eld_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mode           (mode),
    .floor          (floor),
    .request_kind   (request_kind),
    .door_open      (door_open),
    .forward_request(forward_request),
    .motor_valid    (motor_valid),
    .motor_cmd      (motor_cmd),
    .open_door      (open_door),
    .hall_clear     (hall_clear),
    .hall_clear_up  (hall_clear_up),
    .car_floor      (car_floor),
    .target_valid   (target_valid),
    .target_floor   (target_floor)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on the cycle after an accept");

  a_reach_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && open_door |-> motor_valid && (motor_cmd == MOTOR_STOP) && !target_valid)
    else $error("target reached without stop");

  a_hall_needs_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && hall_clear |-> open_door)
    else $error("hall clear without door open");

  a_hall_up_needs_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && hall_clear_up |-> hall_clear)
    else $error("hall up flag without hall clear");
`endif

endmodule

// ===== hw/rtl/eld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module eld_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/eld_ctrl.sv =====
// Controller: sequences one item through compute and result stages.
module eld_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output eld_pkg::eld_cmd_t cmd
);
  import eld_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_FIN} state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) || ((state == S_FIN) && out_free));

  always_comb begin
    cmd.latch    = in_valid && !in_stall;
    cmd.commit   = (state == S_CALC);
    cmd.load_out = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= in_valid ? S_CALC : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/eld_datapath.sv =====
// Datapath: request store, car state, target search and result registers.
module eld_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  eld_pkg::eld_cmd_t           cmd,
  input  logic [1:0]                  mode,
  input  logic [eld_pkg::FIELD_W-1:0] floor,
  input  logic [1:0]                  request_kind,
  input  logic                        door_open,
  output logic                        forward_request,
  output logic                        motor_valid,
  output logic [1:0]                  motor_cmd,
  output logic                        open_door,
  output logic                        hall_clear,
  output logic                        hall_clear_up,
  output logic [eld_pkg::FIELD_W-1:0] car_floor,
  output logic                        target_valid,
  output logic [eld_pkg::FIELD_W-1:0] target_floor
);
  import eld_pkg::*;

  // latched item
  logic [1:0]         mode_q;
  logic [FIELD_W-1:0] floor_q;
  logic [1:0]         kind_q;
  logic               door_q;

  // car state
  logic [FLOOR_COUNT-1:0] bm;
  logic [FLOOR_W-1:0]     cur;
  logic [1:0]             dir;
  logic                   tset;
  logic [FLOOR_W-1:0]     tgt;

  // pending result
  logic               fwd_r, mv_r, od_r, occ_r, tv_r;
  logic [1:0]         mc_r;
  logic [FLOOR_W-1:0] carf_r, tf_r;

  logic [1:0] ram_rdata;

  // combinational
  logic                   req_ok, ram_we;
  logic [IDX_W-1:0]       req_idx, cur_idx, new_idx;
  logic                   above_hit, below_hit;
  logic [IDX_W-1:0]       above_idx, below_idx;
  logic [FLOOR_W-1:0]     a_fl, b_fl;
  logic                   cset;
  logic [1:0]             cdir;
  logic [FLOOR_W-1:0]     ctgt;
  logic [FLOOR_COUNT-1:0] bm_next;
  logic [FLOOR_W-1:0]     cur_next, tgt_next;
  logic [1:0]             dir_next;
  logic                   tset_next;
  logic                   fwd, mv, chk, reach;
  logic [1:0]             mc;

  assign cur_idx = IDX_W'(cur - FLOOR_W'(1));
  assign req_idx = IDX_W'(floor_q - FIELD_W'(1));

  // nearest request strictly above / below the current floor
  always_comb begin
    above_hit = 1'b0;
    above_idx = '0;
    below_hit = 1'b0;
    below_idx = '0;
    for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
      if (bm[i] && ((i + 1) > int'(cur))) begin
        above_hit = 1'b1;
        above_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      if (bm[i] && ((i + 1) < int'(cur))) begin
        below_hit = 1'b1;
        below_idx = IDX_W'(i);
      end
    end
  end

  assign a_fl = FLOOR_W'(above_idx) + FLOOR_W'(1);
  assign b_fl = FLOOR_W'(below_idx) + FLOOR_W'(1);

  // target choice
  always_comb begin
    cset = 1'b0;
    cdir = DIR_IDLE;
    ctgt = tgt;
    if ((dir == DIR_UP) || (dir == DIR_DOWN)) begin
      cset = (dir == DIR_UP) ? above_hit : below_hit;
      ctgt = (dir == DIR_UP) ? a_fl : b_fl;
      cdir = cset ? dir : DIR_IDLE;
    end else if (bm[cur_idx]) begin
      cset = 1'b1;
      ctgt = cur;
    end else if (above_hit || below_hit) begin
      cset = 1'b1;
      if (!below_hit || (above_hit && ((a_fl - cur) < (cur - b_fl)))) begin
        ctgt = a_fl;
        cdir = DIR_UP;
      end else begin
        ctgt = b_fl;
        cdir = DIR_DOWN;
      end
    end
  end

  // event handling
  always_comb begin
    bm_next   = bm;
    cur_next  = cur;
    dir_next  = dir;
    tset_next = tset;
    tgt_next  = tgt;
    fwd       = 1'b0;
    mv        = 1'b0;
    mc        = MOTOR_STOP;
    chk       = 1'b0;
    req_ok    = (32'(floor_q) >= 32'd1) && (32'(floor_q) <= 32'(FLOOR_COUNT)) &&
                (kind_q != KIND_NONE) && !bm[req_idx];
    ram_we    = 1'b0;
    case (mode_q)
      MODE_REQUEST: begin
        if (req_ok) begin
          bm_next[req_idx] = 1'b1;
          fwd              = 1'b1;
          ram_we           = cmd.commit;
        end
      end
      MODE_ARRIVE: begin
        if ((dir == DIR_UP) && (cur < FLOOR_W'(FLOOR_COUNT))) begin
          cur_next = cur + FLOOR_W'(1);
        end else if ((dir == DIR_DOWN) && (cur > FLOOR_W'(1))) begin
          cur_next = cur - FLOOR_W'(1);
        end
        chk = 1'b1;
      end
      default: begin
        dir_next  = cdir;
        tset_next = cset;
        tgt_next  = ctgt;
        chk       = 1'b1;
        if (!(cset && (ctgt == cur)) && !door_q) begin
          mv = 1'b1;
          mc = cdir;
        end
      end
    endcase
    new_idx = IDX_W'(cur_next - FLOOR_W'(1));
    reach   = chk && tset_next && (tgt_next == cur_next);
    if (reach) begin
      dir_next         = DIR_IDLE;
      mv               = 1'b1;
      mc               = MOTOR_STOP;
      bm_next[new_idx] = 1'b0;
      tset_next        = 1'b0;
    end
  end

  eld_ram #(
    .WIDTH(2),
    .DEPTH(FLOOR_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(req_idx),
    .wdata(kind_q),
    .raddr(new_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bm   <= '0;
      cur  <= FLOOR_W'(1);
      dir  <= DIR_IDLE;
      tset <= 1'b0;
      tgt  <= FLOOR_W'(1);
    end else if (cmd.commit) begin
      bm   <= bm_next;
      cur  <= cur_next;
      dir  <= dir_next;
      tset <= tset_next;
      tgt  <= tgt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q  <= mode;
      floor_q <= floor;
      kind_q  <= request_kind;
      door_q  <= door_open;
    end
    if (cmd.commit) begin
      fwd_r  <= fwd;
      mv_r   <= mv;
      mc_r   <= mc;
      od_r   <= reach;
      occ_r  <= bm[new_idx];
      carf_r <= cur_next;
      tv_r   <= tset_next;
      tf_r   <= tgt_next;
    end
    if (cmd.load_out) begin
      forward_request <= fwd_r;
      motor_valid     <= mv_r;
      motor_cmd       <= mc_r;
      open_door       <= od_r;
      hall_clear      <= od_r && occ_r && (ram_rdata > KIND_CAR);
      hall_clear_up   <= od_r && occ_r && (ram_rdata == KIND_HALL_UP);
      car_floor       <= FIELD_W'(carf_r);
      target_valid    <= tv_r;
      target_floor    <= tv_r ? FIELD_W'(tf_r) : '0;
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Testbench for the elevator LOOK dispatcher: directed and random events checked against a predictor.
`timescale 1ns / 100ps

module testbench;
  import eld_pkg::*;

  localparam logic [1:0] KIND_HALL_DN = 2'd3;
  localparam int RANDOM_EVENTS = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FIELD_W-1:0] floor;
    logic [1:0]         kind;
    logic               door;
  } car_input_t;

  typedef struct packed {
    logic               forward_request;
    logic               motor_valid;
    logic [1:0]         motor_cmd;
    logic               open_door;
    logic               hall_clear;
    logic               hall_clear_up;
    logic [FIELD_W-1:0] car_floor;
    logic               target_valid;
    logic [FIELD_W-1:0] target_floor;
  } car_status_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_REQUEST;
  logic [FIELD_W-1:0] floor = '0;
  logic [1:0]         request_kind = KIND_NONE;
  logic               door_open = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               forward_request;
  logic               motor_valid;
  logic [1:0]         motor_cmd;
  logic               open_door;
  logic               hall_clear;
  logic               hall_clear_up;
  logic [FIELD_W-1:0] car_floor;
  logic               target_valid;
  logic [FIELD_W-1:0] target_floor;

  elevator_look_dispatcher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .floor(floor),
    .request_kind(request_kind),
    .door_open(door_open),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .forward_request(forward_request),
    .motor_valid(motor_valid),
    .motor_cmd(motor_cmd),
    .open_door(open_door),
    .hall_clear(hall_clear),
    .hall_clear_up(hall_clear_up),
    .car_floor(car_floor),
    .target_valid(target_valid),
    .target_floor(target_floor)
  );

  car_input_t  call_feed[$];
  car_status_t status_due[$];
  int          feed_total = 0;
  int          n_accepted = 0;
  int          n_failures = 0;
  int          cycles = 0;
  bit          item_taken = 1'b0;
  bit          timed_out = 1'b0;

  // predictor state
  logic [1:0] calls [1:FLOOR_COUNT];
  int         car_at;
  logic [1:0] heading;
  bit         dest_set;
  int         dest;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int call_above();
    for (int f = car_at + 1; f <= FLOOR_COUNT; f++)
      if (calls[f] != KIND_NONE) return f;
    return 0;
  endfunction

  function automatic int call_below();
    for (int f = car_at - 1; f >= 1; f--)
      if (calls[f] != KIND_NONE) return f;
    return 0;
  endfunction

  function automatic void pick_destination();
    int ahead;
    int up_f;
    int dn_f;
    dest_set = 1'b0;
    if (heading == DIR_UP || heading == DIR_DOWN) begin
      ahead = (heading == DIR_UP) ? call_above() : call_below();
      if (ahead != 0) begin
        dest_set = 1'b1;
        dest = ahead;
      end else begin
        heading = DIR_IDLE;
      end
      return;
    end
    heading = DIR_IDLE;
    if (calls[car_at] != KIND_NONE) begin
      dest_set = 1'b1;
      dest = car_at;
      return;
    end
    up_f = call_above();
    dn_f = call_below();
    if (up_f == 0 && dn_f == 0) return;
    dest_set = 1'b1;
    // equal distance goes down
    if (dn_f == 0 || (up_f != 0 && (up_f - car_at) < (car_at - dn_f))) begin
      dest = up_f;
      heading = DIR_UP;
    end else begin
      dest = dn_f;
      heading = DIR_DOWN;
    end
  endfunction

  function automatic car_status_t advance_car(car_input_t ev);
    car_status_t r;
    logic [1:0]  served;
    bit          check;
    r = '0;
    check = 1'b0;
    case (ev.mode)
      MODE_REQUEST: begin
        if (ev.floor >= 1 && ev.floor <= FLOOR_COUNT && ev.kind != KIND_NONE &&
            calls[ev.floor] == KIND_NONE) begin
          calls[ev.floor] = ev.kind;
          r.forward_request = 1'b1;
        end
      end
      MODE_ARRIVE: begin
        if (heading == DIR_UP && car_at < FLOOR_COUNT) car_at++;
        else if (heading == DIR_DOWN && car_at > 1) car_at--;
        check = 1'b1;
      end
      default: begin
        pick_destination();
        check = 1'b1;
        if (!(dest_set && dest == car_at) && !ev.door) begin
          r.motor_valid = 1'b1;
          r.motor_cmd = heading;
        end
      end
    endcase
    if (check && dest_set && dest == car_at) begin
      served = calls[car_at];
      heading = DIR_IDLE;
      r.motor_valid = 1'b1;
      r.motor_cmd = MOTOR_STOP;
      if (served == KIND_HALL_UP || served == KIND_HALL_DN) begin
        r.hall_clear = 1'b1;
        r.hall_clear_up = (served == KIND_HALL_UP);
      end
      calls[car_at] = KIND_NONE;
      dest_set = 1'b0;
      r.open_door = 1'b1;
    end
    r.car_floor = FIELD_W'(car_at);
    r.target_valid = dest_set;
    r.target_floor = dest_set ? FIELD_W'(dest) : '0;
    return r;
  endfunction

  function automatic string show(car_status_t s);
    return $sformatf({"fwd=%0d mv=%0d cmd=%0d open=%0d hc=%0d hcu=%0d ",
                      "floor=%0d tv=%0d tf=%0d"},
                     s.forward_request, s.motor_valid, s.motor_cmd, s.open_door,
                     s.hall_clear, s.hall_clear_up, s.car_floor, s.target_valid,
                     s.target_floor);
  endfunction

  task automatic add(logic [1:0] m, int fl, logic [1:0] k, logic d);
    car_input_t ev;
    ev.mode = m;
    ev.floor = FIELD_W'(fl);
    ev.kind = k;
    ev.door = d;
    call_feed.push_back(ev);
  endtask

  // driver: new item only when the last one was taken
  always @(negedge clk) begin
    car_input_t nxt;
    int gap_pct;
    int stall_pct;
    if (n_accepted < feed_total / 3) begin
      gap_pct = 28;
      stall_pct = 54;
    end else if (n_accepted < 2 * feed_total / 3) begin
      gap_pct = 54;
      stall_pct = 28;
    end else begin
      gap_pct = 0;
      stall_pct = 0;
    end
    if (!rst) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || item_taken) begin
        if (call_feed.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = call_feed.pop_front();
          in_valid <= 1'b1;
          mode <= nxt.mode;
          floor <= nxt.floor;
          request_kind <= nxt.kind;
          door_open <= nxt.door;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk) begin
    car_status_t got;
    car_status_t want;
    cycles++;
    item_taken = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      status_due.push_back(advance_car({mode, floor, request_kind, door_open}));
      n_accepted++;
      item_taken = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      got = {forward_request, motor_valid, motor_cmd, open_door, hall_clear,
             hall_clear_up, car_floor, target_valid, target_floor};
      if (status_due.size() == 0) begin
        n_failures++;
        if (n_failures <= 10)
          $display("unexpected result at cycle %0d: %s", cycles, show(got));
      end else begin
        want = status_due.pop_front();
        if (got !== want) begin
          n_failures++;
          if (n_failures <= 10)
            $display("mismatch at cycle %0d\n  exp %s\n  got %s",
                     cycles, show(want), show(got));
        end
      end
    end
  end

  initial begin
    int r;
    logic [1:0] m;
    for (int f = 1; f <= FLOOR_COUNT; f++) calls[f] = KIND_NONE;
    car_at = 1;
    heading = DIR_IDLE;
    dest_set = 1'b0;
    dest = 1;

    add(MODE_UPDATE, 0, KIND_NONE, 1'b0);        // idle, nothing stored
    add(MODE_REQUEST, 1, KIND_CAR, 1'b0);
    add(MODE_REQUEST, 1, KIND_HALL_UP, 1'b0);    // duplicate, ignored
    add(MODE_UPDATE, 1, KIND_NONE, 1'b1);        // serve current floor, door open
    add(MODE_REQUEST, 0, KIND_CAR, 1'b0);
    add(MODE_REQUEST, 17, KIND_CAR, 1'b0);
    add(MODE_REQUEST, 31, KIND_HALL_DN, 1'b1);
    add(MODE_REQUEST, 5, KIND_NONE, 1'b0);
    add(MODE_ARRIVE, 15, KIND_CAR, 1'b0);        // idle arrival, stays
    add(MODE_REQUEST, 5, KIND_CAR, 1'b1);
    add(MODE_REQUEST, 16, KIND_HALL_DN, 1'b0);
    add(MODE_UPDATE, 0, KIND_NONE, 1'b0);
    repeat (4) add(MODE_ARRIVE, 0, KIND_NONE, 1'b0);
    add(MODE_REQUEST, 3, KIND_HALL_UP, 1'b0);
    add(MODE_REQUEST, 7, KIND_HALL_DN, 1'b0);
    add(MODE_CLOSED, 0, KIND_NONE, 1'b1);        // tie goes down, motor held
    repeat (2) add(MODE_ARRIVE, 0, KIND_NONE, 1'b1);
    add(MODE_CLOSED, 0, KIND_NONE, 1'b0);
    add(MODE_UPDATE, 0, KIND_NONE, 1'b0);
    add(MODE_REQUEST, 15, KIND_CAR, 1'b0);

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      r = $urandom_range(99);
      if (r < 30) m = MODE_REQUEST;
      else if (r < 70) m = MODE_ARRIVE;
      else if (r < 88) m = MODE_UPDATE;
      else m = MODE_CLOSED;
      add(m,
          ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(FLOOR_COUNT, 1),
          ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(3, 1)),
          1'($urandom_range(3) == 0));
    end
    feed_total = call_feed.size();

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (!(n_accepted == feed_total && status_due.size() == 0) && cycles < CYCLE_LIMIT)
      @(posedge clk);
    timed_out = (cycles >= CYCLE_LIMIT);
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);

    if (!timed_out && n_failures == 0 && status_due.size() == 0)
      $display("[elevator_look_dispatcher] OK");
    else
      $display("[elevator_look_dispatcher] ERROR");
    $finish;
  end

endmodule
